// ===== hw/rtl/wpcs_pkg.sv =====
// Shared types for the weight pair canonical sort block.
// Holds the sort key type and the controller to datapath command bundle.
// No dependencies.
package wpcs_pkg;

  // Sort key: upper half is the leading component, lower half the trailing one.
  typedef logic [63:0] key_t;

  // Controller state, one-hot.
  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_DECIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // insert the incoming column into both chains
    logic decide;  // compare the two sorted lists and latch the choice
    logic shift;   // present the chosen head and advance both chains
    logic last;    // the column being presented is the final one
  } cmd_t;

endpackage

// ===== hw/rtl/wpcs_chain.sv =====
// Insertion chain that keeps DIM keys in descending order.
// Also shifts towards the head for read-out. Depends on wpcs_pkg.
module wpcs_chain #(
  parameter int DIM = 5
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      shift,
  input  logic [$clog2(DIM)-1:0]    count,
  input  wpcs_pkg::key_t            key_in,
  output wpcs_pkg::key_t            cells_o [DIM]
);

  localparam int CW = $clog2(DIM);

  wpcs_pkg::key_t cells_r   [DIM];
  wpcs_pkg::key_t cells_nxt [DIM];
  logic [DIM-1:0] keep;

  // A cell keeps its key when it is occupied and not below the new key; the
  // occupied cells are sorted, so the kept cells form a prefix.
  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      keep[i] = (CW'(i) < count) && (cells_r[i] >= key_in);
    end
    for (int i = 0; i < DIM; i++) begin
      cells_nxt[i] = cells_r[i];
      if (load) begin
        if (keep[i]) begin
          cells_nxt[i] = cells_r[i];
        end else if (i == 0) begin
          cells_nxt[i] = key_in;
        end else if (keep[i-1]) begin
          cells_nxt[i] = key_in;
        end else begin
          cells_nxt[i] = cells_r[i-1];
        end
      end else if (shift && (i < DIM - 1)) begin
        cells_nxt[i] = cells_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIM; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  assign cells_o = cells_r;

endmodule

// ===== hw/rtl/wpcs_dp.sv =====
// Datapath: the direct and swapped insertion chains, list comparison and
// the result registers. Depends on wpcs_pkg and wpcs_chain.
module wpcs_dp #(
  parameter int DIM = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wpcs_pkg::cmd_t         cmd,
  input  logic [$clog2(DIM)-1:0] count,
  input  logic [31:0]            weight_first,
  input  logic [31:0]            weight_second,
  output logic                   out_valid,
  output logic [31:0]            out_first,
  output logic [31:0]            out_second,
  output logic                   out_is_last
);

  wpcs_pkg::key_t direct_cells  [DIM];
  wpcs_pkg::key_t swapped_cells [DIM];
  wpcs_pkg::key_t head;

  logic        use_direct_r, use_direct_nxt;
  logic        valid_r;
  logic [31:0] first_r, second_r;
  logic        last_r;

  wpcs_chain #(.DIM(DIM)) u_direct (
    .clk    (clk),
    .load   (cmd.load),
    .shift  (cmd.shift),
    .count  (count),
    .key_in ({weight_first, weight_second}),
    .cells_o(direct_cells)
  );

  wpcs_chain #(.DIM(DIM)) u_swapped (
    .clk    (clk),
    .load   (cmd.load),
    .shift  (cmd.shift),
    .count  (count),
    .key_in ({weight_second, weight_first}),
    .cells_o(swapped_cells)
  );

  // The first differing position decides; scanning from the tail lets the
  // lowest differing position win. Identical lists keep the direct one.
  always_comb begin
    use_direct_nxt = 1'b1;
    for (int i = DIM - 1; i >= 0; i--) begin
      if (direct_cells[i] != swapped_cells[i]) begin
        use_direct_nxt = direct_cells[i] > swapped_cells[i];
      end
    end
  end

  assign head = use_direct_r ? direct_cells[0] : swapped_cells[0];

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      use_direct_r <= use_direct_nxt;
    end
    if (cmd.shift) begin
      first_r  <= head[63:32];
      second_r <= head[31:0];
      last_r   <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.shift;
    end
  end

  assign out_valid   = valid_r;
  assign out_first   = first_r;
  assign out_second  = second_r;
  assign out_is_last = last_r;

endmodule

// ===== hw/rtl/wpcs_ctrl.sv =====
// Controller: counts loaded columns, then sequences the decision and the
// read-out of the chosen list. Depends on wpcs_pkg.
module wpcs_ctrl #(
  parameter int DIM = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output wpcs_pkg::cmd_t         cmd,
  output logic [$clog2(DIM)-1:0] count
);

  localparam int CW = $clog2(DIM);
  localparam logic [CW-1:0] LastIdx = CW'(DIM - 1);

  wpcs_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd       = '0;
    case (state_r)
      wpcs_pkg::ST_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (count_r == LastIdx) begin
            count_nxt = '0;
            state_nxt = wpcs_pkg::ST_DECIDE;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      wpcs_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = wpcs_pkg::ST_EMIT;
      end
      wpcs_pkg::ST_EMIT: begin
        cmd.shift = 1'b1;
        cmd.last  = (count_r == LastIdx);
        if (count_r == LastIdx) begin
          count_nxt = '0;
          state_nxt = wpcs_pkg::ST_LOAD;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      default: begin
        state_nxt = wpcs_pkg::ST_LOAD;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpcs_pkg::ST_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign busy  = (state_r != wpcs_pkg::ST_LOAD);
  assign count = count_r;

endmodule

// ===== hw/rtl/weight_pair_canonical_sort.sv =====
// Canonical sort of a pair of weight vectors, one column per request.
// Throughput: one column per cycle while loading. After the DIM-th request the
// block makes its decision and then reads out the chosen list; it takes no new
// column until the read-out is done.
// Reset (rst_n low, synchronous) empties the column count and drops out_valid.
//
// Each request inserts its column into two descending insertion chains: one
// keyed on (first, second), the other on (second, first). Ties are placed
// behind equal keys, which is harmless because equal keys are identical.
// Once the DIM-th column is in, busy rises. In the decision cycle all DIM
// positions of the two chains are compared side by side and the first
// differing position chooses the greater list; identical lists keep the direct
// one. The chosen list is then shifted out from its head, one result per
// cycle, each held on the outputs for exactly one cycle with out_valid high.
// out_is_last marks the final column. The receiver cannot stall the results.
module weight_pair_canonical_sort #(
  parameter int DIM = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_weight_first,
  input  logic [31:0] in_weight_second,
  output logic        out_valid,
  output logic [31:0] out_first,
  output logic [31:0] out_second,
  output logic        out_is_last
);

  // Commands and the shared column / read-out index run from the controller to
  // the datapath; nothing else joins the two.
  wpcs_pkg::cmd_t         cmd;
  logic [$clog2(DIM)-1:0] count;

  wpcs_ctrl #(.DIM(DIM)) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .count(count)
  );

  wpcs_dp #(.DIM(DIM)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .count        (count),
    .weight_first (in_weight_first),
    .weight_second(in_weight_second),
    .out_valid    (out_valid),
    .out_first    (out_first),
    .out_second   (out_second),
    .out_is_last  (out_is_last)
  );

endmodule
